@@ sv/dtd_pkg.sv @@
// Shared types, constants and the month table for the date-time difference block.
// No dependencies; every other file refers to it by scoped names.
package dtd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SPAN_D_W = 22;

    localparam int N_W      = 15;   // year + 399
    localparam int ORD_W    = 23;   // day ordinal
    localparam int SOD_W    = 17;   // seconds of day, out-of-range fields included
    localparam int DBM_W    = 9;

    localparam int YEAR_SHIFT    = 399;
    localparam int DAYS_PER_YEAR = 365;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int CENTURY       = 100;
    localparam int MAX_DAYS      = 4194303;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MIN       = 59;

    // Reciprocal multipliers: x / 100 = (x * 5243) >> 19 for x < 2^15,
    // x / 3600 = (x * 298262) >> 30 for x < 86400,
    // x / 60 = (x * 17477) >> 20 for x < 3600.
    localparam int RECIP_100  = 5243;
    localparam int RECIP_3600 = 298262;
    localparam int RECIP_60   = 17477;

    typedef struct packed {
        logic [YEAR_W-1:0]  begin_year;
        logic [MONTH_W-1:0] begin_month;
        logic [DAY_W-1:0]   begin_day;
        logic [HOUR_W-1:0]  begin_hour;
        logic [MIN_W-1:0]   begin_minute;
        logic [SEC_W-1:0]   begin_second;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic [HOUR_W-1:0]  end_hour;
        logic [MIN_W-1:0]   end_minute;
        logic [SEC_W-1:0]   end_second;
    } t_in_word;

    typedef struct packed {
        logic [SPAN_D_W-1:0] day_count;
        logic [HOUR_W-1:0]   span_hours;
        logic [MIN_W-1:0]    span_minutes;
        logic [SEC_W-1:0]    span_seconds;
        logic                in_order;
    } t_out_word;

    // One date after the first stage: shifted year, partial quotients and offsets.
    typedef struct packed {
        logic [YEAR_W-1:0] y;
        logic [N_W-1:0]    n;
        logic [12:0]       q4;
        logic [27:0]       p100;   // n * RECIP_100
        logic [25:0]       p400;   // (n / 4) * RECIP_100
        logic [26:0]       py;     // y * RECIP_100
        logic [DBM_W-1:0]  dbm;
        logic              late;   // month 3 or above
        logic [DAY_W-1:0]  d;
        logic [SOD_W-1:0]  secs;
    } t_date_a;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

endpackage

@@ sv/dtd_date_front.sv @@
// First-stage logic for one date: shifted year, reciprocal products, month offset.
// Depends on dtd_pkg.
module dtd_date_front (
    input  logic [dtd_pkg::YEAR_W-1:0]  i_year,
    input  logic [dtd_pkg::MONTH_W-1:0] i_month,
    input  logic [dtd_pkg::DAY_W-1:0]   i_day,
    input  logic [dtd_pkg::HOUR_W-1:0]  i_hour,
    input  logic [dtd_pkg::MIN_W-1:0]   i_minute,
    input  logic [dtd_pkg::SEC_W-1:0]   i_second,
    output dtd_pkg::t_date_a            o_date
);

    logic [dtd_pkg::N_W-1:0] w_n;

    assign w_n = dtd_pkg::N_W'(i_year) + dtd_pkg::N_W'(dtd_pkg::YEAR_SHIFT);

    always_comb begin
        o_date.y    = i_year;
        o_date.n    = w_n;
        o_date.q4   = w_n[14:2];
        o_date.p100 = 28'(w_n) * 28'(dtd_pkg::RECIP_100);
        o_date.p400 = 26'(w_n[14:2]) * 26'(dtd_pkg::RECIP_100);
        o_date.py   = 27'(i_year) * 27'(dtd_pkg::RECIP_100);
        o_date.dbm  = dtd_pkg::days_before_month(i_month);
        o_date.late = (i_month >= 4'd3);
        o_date.d    = i_day;
        o_date.secs = dtd_pkg::SOD_W'(i_hour) * dtd_pkg::SOD_W'(dtd_pkg::SECS_PER_HOUR)
                    + dtd_pkg::SOD_W'(i_minute) * dtd_pkg::SOD_W'(dtd_pkg::SECS_PER_MIN)
                    + dtd_pkg::SOD_W'(i_second);
    end

endmodule

@@ sv/dtd_date_back.sv @@
// Second-stage logic for one date: quotients, leap flag and the day ordinal.
// Depends on dtd_pkg.
module dtd_date_back (
    input  dtd_pkg::t_date_a            i_date,
    output logic [dtd_pkg::ORD_W-1:0]   o_ord
);

    logic [8:0] w_q100;
    logic [6:0] w_q400;
    logic [7:0] w_qy;
    logic       w_cent;
    logic       w_leap;

    assign w_q100 = i_date.p100[27:19];
    assign w_q400 = i_date.p400[25:19];
    assign w_qy   = i_date.py[26:19];

    // century year when y equals its own quotient times 100
    assign w_cent = (i_date.y == 14'(w_qy) * 14'(dtd_pkg::CENTURY));
    assign w_leap = w_cent ? (w_qy[1:0] == 2'd0) : (i_date.y[1:0] == 2'd0);

    assign o_ord = dtd_pkg::ORD_W'(i_date.n) * dtd_pkg::ORD_W'(dtd_pkg::DAYS_PER_YEAR)
                 + dtd_pkg::ORD_W'(i_date.q4)
                 - dtd_pkg::ORD_W'(w_q100)
                 + dtd_pkg::ORD_W'(w_q400)
                 + dtd_pkg::ORD_W'(i_date.dbm)
                 + dtd_pkg::ORD_W'(i_date.late & w_leap)
                 + dtd_pkg::ORD_W'(i_date.d);

endmodule

@@ sv/datetime_difference.sv @@
// Top level of the date-time difference pipeline.
// Depends on dtd_pkg, dtd_date_front and dtd_date_back.
//   Input channel : i_in_valid / o_in_stall, word i_in_word (begin and end
//                   date-time). A word is taken on a rising edge with valid
//                   high and stall low.
//   Output channel: o_out_valid / i_out_stall, word o_out_word (days, hours,
//                   minutes, seconds of the span and the in_order flag).
//   Stages        : six register stages: A front products, B ordinals and
//                   second split, C day span and hour product, D hour
//                   remainder, E minute product, F output register.
//   Throughput    : one word per cycle while the output is not stalled;
//                   each stage holds one word.
//   Stall         : each stage moves when it is empty or the stage after it
//                   moves, so bubbles are squeezed out. The input sees stall
//                   only when all six stages hold a word and the output is
//                   stalled. Nothing is dropped or repeated.
//   Reset         : i_rst_n low on a rising edge empties every stage; the
//                   output is not valid on the next cycle.
// Begin later than end: zero span, in_order low; long spans saturate.
module datetime_difference (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtd_pkg::t_out_word o_out_word
);

    localparam int NSTG = 6;

    // ---- stage handshake ----
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---- stage A: per-date products, order compare ----
    dtd_pkg::t_date_a n_a_beg, n_a_end;
    logic             n_a_ord;

    dtd_date_front u_front_beg (
        .i_year   (i_in_word.begin_year),
        .i_month  (i_in_word.begin_month),
        .i_day    (i_in_word.begin_day),
        .i_hour   (i_in_word.begin_hour),
        .i_minute (i_in_word.begin_minute),
        .i_second (i_in_word.begin_second),
        .o_date   (n_a_beg)
    );

    dtd_date_front u_front_end (
        .i_year   (i_in_word.end_year),
        .i_month  (i_in_word.end_month),
        .i_day    (i_in_word.end_day),
        .i_hour   (i_in_word.end_hour),
        .i_minute (i_in_word.end_minute),
        .i_second (i_in_word.end_second),
        .o_date   (n_a_end)
    );

    // field-by-field order is the unsigned order of the concatenation
    assign n_a_ord = !({i_in_word.begin_year, i_in_word.begin_month, i_in_word.begin_day,
                        i_in_word.begin_hour, i_in_word.begin_minute,
                        i_in_word.begin_second}
                     > {i_in_word.end_year, i_in_word.end_month, i_in_word.end_day,
                        i_in_word.end_hour, i_in_word.end_minute, i_in_word.end_second});

    dtd_pkg::t_date_a r_a_beg, r_a_end;
    logic             r_a_ord;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_beg <= n_a_beg;
            r_a_end <= n_a_end;
            r_a_ord <= n_a_ord;
        end
    end

    // ---- stage B: ordinals, split of the second difference into days ----
    localparam logic signed [18:0] DAY_S = 19'(dtd_pkg::SECS_PER_DAY);

    logic [dtd_pkg::ORD_W-1:0] n_b_ob, n_b_oe;
    logic signed [18:0]        w_sdiff;
    logic signed [1:0]         n_b_q;
    logic [dtd_pkg::SOD_W-1:0] n_b_rem;

    dtd_date_back u_back_beg (.i_date(r_a_beg), .o_ord(n_b_ob));
    dtd_date_back u_back_end (.i_date(r_a_end), .o_ord(n_b_oe));

    assign w_sdiff = $signed(19'(r_a_end.secs)) - $signed(19'(r_a_beg.secs));

    // floor division by one day; the difference stays above minus two days
    always_comb begin
        if (w_sdiff >= DAY_S) begin
            n_b_q   = 2'sd1;
            n_b_rem = dtd_pkg::SOD_W'(w_sdiff - DAY_S);
        end else if (w_sdiff >= 19'sd0) begin
            n_b_q   = 2'sd0;
            n_b_rem = dtd_pkg::SOD_W'(w_sdiff);
        end else if (w_sdiff >= -DAY_S) begin
            n_b_q   = -2'sd1;
            n_b_rem = dtd_pkg::SOD_W'(w_sdiff + DAY_S);
        end else begin
            n_b_q   = -2'sd2;
            n_b_rem = dtd_pkg::SOD_W'(w_sdiff + DAY_S + DAY_S);
        end
    end

    logic [dtd_pkg::ORD_W-1:0] r_b_ob, r_b_oe;
    logic signed [1:0]         r_b_q;
    logic [dtd_pkg::SOD_W-1:0] r_b_rem;
    logic                      r_b_ord;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_ob  <= n_b_ob;
            r_b_oe  <= n_b_oe;
            r_b_q   <= n_b_q;
            r_b_rem <= n_b_rem;
            r_b_ord <= r_a_ord;
        end
    end

    // ---- stage C: whole days, zero / saturate flags, hour product ----
    logic signed [24:0] w_days;
    logic               n_c_zero;
    logic               n_c_sat;

    assign w_days = $signed({2'b00, r_b_oe}) - $signed({2'b00, r_b_ob}) + 25'(r_b_q);
    assign n_c_zero = !r_b_ord || (w_days < 25'sd0)
                    || ((w_days == 25'sd0) && (r_b_rem == '0));
    assign n_c_sat  = w_days > 25'(dtd_pkg::MAX_DAYS);

    logic [dtd_pkg::SPAN_D_W-1:0] r_c_days;
    logic [dtd_pkg::SOD_W-1:0]    r_c_rem;
    logic [35:0]                  r_c_ph;
    logic                         r_c_zero, r_c_sat, r_c_ord;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_c_days <= w_days[dtd_pkg::SPAN_D_W-1:0];
            r_c_rem  <= r_b_rem;
            r_c_ph   <= 36'(r_b_rem) * 36'(dtd_pkg::RECIP_3600);
            r_c_zero <= n_c_zero;
            r_c_sat  <= n_c_sat;
            r_c_ord  <= r_b_ord;
        end
    end

    // ---- stage D: hours and the seconds left within the hour ----
    logic [dtd_pkg::HOUR_W-1:0] w_d_h;
    logic [11:0]                n_d_r2;

    assign w_d_h  = r_c_ph[34:30];
    assign n_d_r2 = 12'(r_c_rem - dtd_pkg::SOD_W'(w_d_h)
                              * dtd_pkg::SOD_W'(dtd_pkg::SECS_PER_HOUR));

    logic [dtd_pkg::SPAN_D_W-1:0] r_d_days;
    logic [dtd_pkg::HOUR_W-1:0]   r_d_h;
    logic [11:0]                  r_d_r2;
    logic                         r_d_zero, r_d_sat, r_d_ord;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_d_days <= r_c_days;
            r_d_h    <= w_d_h;
            r_d_r2   <= n_d_r2;
            r_d_zero <= r_c_zero;
            r_d_sat  <= r_c_sat;
            r_d_ord  <= r_c_ord;
        end
    end

    // ---- stage E: minute product ----
    logic [dtd_pkg::SPAN_D_W-1:0] r_e_days;
    logic [dtd_pkg::HOUR_W-1:0]   r_e_h;
    logic [11:0]                  r_e_r2;
    logic [26:0]                  r_e_pm;
    logic                         r_e_zero, r_e_sat, r_e_ord;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_e_days <= r_d_days;
            r_e_h    <= r_d_h;
            r_e_r2   <= r_d_r2;
            r_e_pm   <= 27'(r_d_r2) * 27'(dtd_pkg::RECIP_60);
            r_e_zero <= r_d_zero;
            r_e_sat  <= r_d_sat;
            r_e_ord  <= r_d_ord;
        end
    end

    // ---- stage F: minutes, seconds, final select into the output register ----
    logic [dtd_pkg::MIN_W-1:0] w_f_mi;
    logic [dtd_pkg::SEC_W-1:0] w_f_s;
    dtd_pkg::t_out_word        n_f_word;

    assign w_f_mi = r_e_pm[25:20];
    assign w_f_s  = dtd_pkg::SEC_W'(r_e_r2 - 12'(w_f_mi) * 12'(dtd_pkg::SECS_PER_MIN));

    always_comb begin
        n_f_word.in_order = r_e_ord;
        if (r_e_zero) begin
            n_f_word.day_count    = '0;
            n_f_word.span_hours   = '0;
            n_f_word.span_minutes = '0;
            n_f_word.span_seconds = '0;
        end else if (r_e_sat) begin
            n_f_word.day_count    = dtd_pkg::SPAN_D_W'(dtd_pkg::MAX_DAYS);
            n_f_word.span_hours   = dtd_pkg::HOUR_W'(dtd_pkg::MAX_HOUR);
            n_f_word.span_minutes = dtd_pkg::MIN_W'(dtd_pkg::MAX_MIN);
            n_f_word.span_seconds = dtd_pkg::SEC_W'(dtd_pkg::MAX_MIN);
        end else begin
            n_f_word.day_count    = r_e_days;
            n_f_word.span_hours   = r_e_h;
            n_f_word.span_minutes = w_f_mi;
            n_f_word.span_seconds = w_f_s;
        end
    end

    dtd_pkg::t_out_word r_f_word;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_f_word <= n_f_word;
        end
    end

    assign o_out_word = r_f_word;

`ifndef SYNTHESIS
    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // reciprocal splits keep the time fields in range
    a_hms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.span_hours <= 5'd23)
                     && (o_out_word.span_minutes <= 6'd59)
                     && (o_out_word.span_seconds <= 6'd59))
        else $error("span time field out of range");

    // out-of-order words carry a zero day count
    a_rev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.in_order) |-> (o_out_word.day_count == '0))
        else $error("nonzero span on reversed input");
`endif

endmodule
